// ===== design/srie_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srie_pkg: shared types and constants
// Request codes, opcodes, result status codes and controller/datapath types.
// ----------------------------------------------------------------------------
package srie_pkg;

  localparam int unsigned MEM_WORDS_DEF = 8192;
  localparam int unsigned NUM_REGS      = 256;
  localparam int unsigned PC_W          = 15;
  localparam int unsigned IN_W          = 56;   // 3+13+32+8 = 56 bits, whole bytes
  localparam int unsigned OUT_W         = 64;   // 2+32+1+8+1+15 = 59, padded to 64

  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_READ  = 3'd1,
    REQ_RREG  = 3'd2,
    REQ_SETPC = 3'd3,
    REQ_STEP  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_EXEC   = 2'd1,
    ST_HALT   = 2'd2,
    ST_FAULT  = 2'd3
  } status_t;

  localparam logic [7:0] OP_LIT  = 8'h80;
  localparam logic [7:0] OP_REL  = 8'h81;
  localparam logic [7:0] OP_JAL  = 8'h82;
  localparam logic [7:0] OP_JALR = 8'h83;
  localparam logic [7:0] OP_BEQZ = 8'h84;
  localparam logic [7:0] OP_BNEZ = 8'h85;
  localparam logic [7:0] OP_ADD  = 8'h86;
  localparam logic [7:0] OP_SUB  = 8'h87;
  localparam logic [7:0] OP_XOR  = 8'h88;
  localparam logic [7:0] OP_OR   = 8'h89;
  localparam logic [7:0] OP_AND  = 8'h8a;
  localparam logic [7:0] OP_SLT  = 8'h8b;
  localparam logic [7:0] OP_SLTU = 8'h8c;
  localparam logic [7:0] OP_SHL  = 8'h8d;
  localparam logic [7:0] OP_SHRL = 8'h8e;
  localparam logic [7:0] OP_SHRA = 8'h8f;
  localparam logic [7:0] OP_LB   = 8'h90;
  localparam logic [7:0] OP_LW   = 8'h91;
  localparam logic [7:0] OP_LD   = 8'h92;
  localparam logic [7:0] OP_SB   = 8'h93;
  localparam logic [7:0] OP_SW   = 8'h94;
  localparam logic [7:0] OP_SD   = 8'h95;
  localparam logic [7:0] OP_SYS  = 8'ha0;
  localparam logic [7:0] OP_GETC = 8'ha1;
  localparam logic [7:0] OP_PUTC = 8'ha2;

  localparam logic [4:0] SHAMT_MASK = 5'h1f;

  typedef enum logic [3:0] {
    S_CLEAR,   // clearing pass over memory and registers after reset
    S_IDLE,
    S_HOST,    // perform host request and issue reads
    S_FETCH,   // issue instruction fetch read
    S_REGS,    // instruction word returns, register reads issued
    S_MEM,     // register operands return, load/store read issued
    S_EXEC,    // load data returns / store merge, write back and build the result
    S_OUT      // hold result until taken
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clr_step;   // clear one memory word (and register, while in range) in this cycle
    logic capture;    // latch input request
    logic host_do;    // perform host request (write/setpc) and issue reads
    logic fetch;      // issue instruction fetch read
    logic dec;        // latch instruction, issue register reads
    logic mem_rd;     // issue data memory read for load/store
    logic commit;     // perform write back and form result
    logic host_res;   // form host result
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_done;
    logic is_step;      // captured request is a step that will execute
    logic host_read;    // host request needs a memory/register read cycle
    logic fetch_bad;    // pc misaligned or out of range
    logic needs_mem;    // decoded op is a load or store that is in range
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/srie_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srie_ctrl: request sequencer
// After the reset clear, runs host requests, and steps through fetch, operand, memory and commit phases.
// ----------------------------------------------------------------------------
module srie_ctrl
  import srie_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_fire,
  input  wire logic    out_fire,
  input  dp_sts_t      sts,
  output logic         in_ready,
  output logic         out_valid,
  output dp_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_fire;
        if (in_fire) begin
          state_nxt = S_HOST;
        end
      end
      S_HOST: begin
        cmd.host_do = 1'b1;
        if (sts.is_step) begin
          state_nxt = S_FETCH;
        end else if (sts.host_read) begin
          state_nxt = S_EXEC;
        end else begin
          cmd.host_res = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (sts.fetch_bad) begin
          cmd.commit = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_REGS;
        end
      end
      S_REGS: begin
        cmd.dec   = 1'b1;
        state_nxt = S_MEM;
      end
      S_MEM: begin
        cmd.mem_rd = sts.needs_mem;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_step) begin
          cmd.commit = 1'b1;
        end else begin
          cmd.host_res = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/srie_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srie_dp: core datapath
// Data memory, register file, pc, run state, ALU and result register.
// ----------------------------------------------------------------------------
module srie_dp
  import srie_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
)(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  dp_cmd_t                cmd,
  input  wire logic [IN_W-1:0]   in_data,
  input  wire logic              in_user,
  output dp_sts_t                sts,
  output logic [OUT_W-1:0]       res_data
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rf  [NUM_REGS];

  // Clearing pass counter: covers the larger of memory and register file.
  localparam int unsigned CLR_N = (MEM_WORDS > NUM_REGS) ? MEM_WORDS : NUM_REGS;
  localparam int unsigned CW    = $clog2(CLR_N);
  logic [CW-1:0] clr_r;

  // Captured request.
  logic [2:0]  req_r;
  logic [12:0] idx_r;
  logic [31:0] val_r;
  logic [7:0]  ch_r;
  logic        eof_r;

  logic [PC_W-1:0] pc_r;
  logic [1:0]      run_r;
  logic            inst_valid_r;

  logic [31:0] mrd_r;   // memory read data
  logic [31:0] rra_r;   // register read port A
  logic [31:0] rrb_r;   // register read port B
  logic [31:0] inst_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0] mem_wd;
  logic        mem_re;
  logic        rf_we;
  logic [7:0]  rf_wa, rf_ra, rf_rb;
  logic [31:0] rf_wd;
  logic        rf_re;

  logic [OUT_W-1:0] res_r;
  assign res_data = res_r;

  // Request decode.
  logic idx_ok_mem, idx_ok_reg;
  assign idx_ok_mem = ({19'd0, idx_r} < 32'(MEM_WORDS));
  assign idx_ok_reg = (idx_r < 13'd256);
  assign sts.clr_done  = (clr_r == CW'(CLR_N - 1));
  assign sts.is_step   = (req_r == REQ_STEP) && (run_r == ST_ACCEPT);
  assign sts.host_read = ((req_r == REQ_READ) && idx_ok_mem) ||
                         ((req_r == REQ_RREG) && idx_ok_reg);

  function automatic logic abad(input logic [1:0] sz, input logic [31:0] a);
    logic mis;
    mis = (sz == 2'd1) ? a[0] : (sz == 2'd2) ? (a[1:0] != 2'd0) : 1'b0;
    return mis || ((a >> 2) >= 32'(MEM_WORDS));
  endfunction

  assign sts.fetch_bad = abad(2'd2, {17'd0, pc_r});

  // Instruction fields (valid from S_MEM on).
  logic [7:0]  op, f1, f2, f3;
  logic [31:0] imm;
  assign op  = inst_r[7:0];
  assign f1  = inst_r[15:8];
  assign f2  = inst_r[23:16];
  assign f3  = inst_r[31:24];
  assign imm = {{16{inst_r[31]}}, inst_r[31:16]};

  logic [1:0]  lsz;
  logic        is_ld, is_st;
  logic [31:0] ea;
  always_comb begin
    is_ld = (op == OP_LB) || (op == OP_LW) || (op == OP_LD);
    is_st = (op == OP_SB) || (op == OP_SW) || (op == OP_SD);
    case (op)
      OP_LB, OP_SB: lsz = 2'd0;
      OP_LW, OP_SW: lsz = 2'd1;
      default:      lsz = 2'd2;
    endcase
  end
  assign ea = rrb_r + {24'd0, f2};
  logic ea_bad;
  assign ea_bad = abad(lsz, ea);
  assign sts.needs_mem = (is_ld || is_st) && !ea_bad;

  // Execute: compute result in commit cycle.
  logic [31:0] pc32, pci, pc4, jt, wb;
  logic [7:0]  wreg;
  logic        wen, fault, halt, taken, pv, gt;
  logic [31:0] lval, sval;
  logic [4:0]  sh;
  logic [4:0]  bsh;
  logic [31:0] nxt;
  always_comb begin
    pc32  = {17'd0, pc_r};
    pci   = pc32 + imm;
    pc4   = pc32 + 32'd4;
    jt    = rra_r + rrb_r;
    sh    = rrb_r[4:0] & SHAMT_MASK;
    bsh   = {ea[1:0], 3'd0};
    wb    = '0;
    wreg  = f1;
    wen   = 1'b0;
    fault = 1'b0;
    halt  = 1'b0;
    taken = 1'b0;
    pv    = 1'b0;
    gt    = 1'b0;
    nxt   = pc4;
    mem_wd = mrd_r;
    lval  = mrd_r >> bsh;
    case (lsz)
      2'd0:    lval = {{24{lval[7]}}, lval[7:0]};
      2'd1:    lval = {{16{lval[15]}}, lval[15:0]};
      default: lval = lval;
    endcase
    sval = mrd_r;
    case (lsz)
      2'd0:    sval = (mrd_r & ~(32'hff << bsh)) | ({24'd0, rra_r[7:0]} << bsh);
      2'd1:    sval = (mrd_r & ~(32'hffff << bsh)) | ({16'd0, rra_r[15:0]} << bsh);
      default: sval = rra_r;
    endcase
    case (op)
      OP_LIT: begin wen = 1'b1; wb = imm; end
      OP_REL: begin wen = 1'b1; wb = pci; end
      OP_JAL: begin
        if (abad(2'd2, pci)) fault = 1'b1;
        else begin wen = 1'b1; wb = pc4; nxt = pci; end
      end
      OP_JALR: begin
        if (abad(2'd2, jt)) fault = 1'b1;
        else begin wen = 1'b1; wreg = f2; wb = pc4; nxt = jt; end
      end
      OP_BEQZ, OP_BNEZ: begin
        taken = (op == OP_BEQZ) == (rra_r == 32'd0);
        if (taken) begin
          if (abad(2'd2, pci)) fault = 1'b1;
          else nxt = pci;
        end
      end
      OP_ADD:  begin wen = 1'b1; wreg = f2; wb = rra_r + rrb_r; end
      OP_SUB:  begin wen = 1'b1; wreg = f2; wb = rra_r - rrb_r; end
      OP_XOR:  begin wen = 1'b1; wreg = f2; wb = rra_r ^ rrb_r; end
      OP_OR:   begin wen = 1'b1; wreg = f2; wb = rra_r | rrb_r; end
      OP_AND:  begin wen = 1'b1; wreg = f2; wb = rra_r & rrb_r; end
      OP_SLT:  begin wen = 1'b1; wreg = f2; wb = {32{$signed(rra_r) < $signed(rrb_r)}}; end
      OP_SLTU: begin wen = 1'b1; wreg = f2; wb = {32{rra_r < rrb_r}}; end
      OP_SHL:  begin wen = 1'b1; wreg = f2; wb = rra_r << sh; end
      OP_SHRL: begin wen = 1'b1; wreg = f2; wb = rra_r >> sh; end
      OP_SHRA: begin wen = 1'b1; wreg = f2; wb = $unsigned($signed(rra_r) >>> sh); end
      OP_LB, OP_LW, OP_LD: begin
        if (ea_bad) fault = 1'b1;
        else begin wen = 1'b1; wb = lval; end
      end
      OP_SB, OP_SW, OP_SD: begin
        if (ea_bad) fault = 1'b1;
        else mem_wd = sval;
      end
      OP_SYS:  begin
        if (f1 != 8'd0 || imm != 32'd0) fault = 1'b1;
        else halt = 1'b1;
      end
      OP_GETC: begin
        if (imm != 32'd0) fault = 1'b1;
        else begin
          wen = 1'b1; gt = 1'b1;
          wb  = eof_r ? 32'hffffffff : {24'd0, ch_r};
        end
      end
      OP_PUTC: begin
        if (imm != 32'd0) fault = 1'b1;
        else pv = 1'b1;
      end
      default: fault = 1'b1;
    endcase
  end

  // Memory and register file port control. The register operands are read
  // straight from the fetched word, as inst_r is loaded at the same edge.
  always_comb begin
    mem_we = 1'b0; mem_wa = idx_r[AW-1:0]; mem_re = 1'b0; mem_ra = idx_r[AW-1:0];
    rf_we  = 1'b0; rf_wa = wreg; rf_wd = wb; rf_re = 1'b0;
    rf_ra  = idx_r[7:0]; rf_rb = f3;
    if (cmd.clr_step) begin
      mem_we = 1'b1; mem_wa = AW'(clr_r); rf_we = (clr_r < CW'(NUM_REGS - 1)) ||
                                                 (clr_r == CW'(NUM_REGS - 1));
      rf_wa = clr_r[7:0]; rf_wd = '0;
    end else if (cmd.host_do) begin
      mem_we = (req_r == REQ_WRITE) && idx_ok_mem;
      mem_re = 1'b1;
      rf_re  = 1'b1;
    end else if (cmd.fetch) begin
      mem_re = 1'b1; mem_ra = pc_r[AW+1:2];
    end else if (cmd.dec) begin
      rf_re = 1'b1;
      rf_ra = mrd_r[15:8];
      rf_rb = mrd_r[31:24];
    end else if (cmd.mem_rd) begin
      mem_re = 1'b1; mem_ra = ea[AW+1:2];
    end else if (cmd.commit && !sts.fetch_bad && inst_valid_r) begin
      rf_we  = wen && !fault;
      mem_we = is_st && !fault;
      mem_wa = ea[AW+1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= cmd.clr_step ? 32'd0 : (cmd.host_do ? val_r : mem_wd);
    if (mem_re) mrd_r <= mem[mem_ra];
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (rf_re) begin
      rra_r <= rf[rf_ra];
      rrb_r <= rf[rf_rb];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= '0;
      pc_r         <= '0;
      run_r        <= ST_ACCEPT;
      inst_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step && !sts.clr_done) clr_r <= clr_r + CW'(1);
      if (cmd.host_do && req_r == REQ_SETPC) begin
        pc_r  <= val_r[PC_W-1:0];
        run_r <= ST_ACCEPT;
      end
      if (cmd.fetch) inst_valid_r <= 1'b0;
      if (cmd.dec) inst_valid_r <= 1'b1;
      if (cmd.commit) begin
        if (sts.fetch_bad || !inst_valid_r || fault) run_r <= ST_FAULT;
        else if (halt) run_r <= ST_HALT;
        else pc_r <= nxt[PC_W-1:0];
      end
    end
  end

  // inst_r is loaded from the fetch read in the register phase.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data[2:0];
      idx_r <= in_data[15:3];
      val_r <= in_data[47:16];
      ch_r  <= in_data[55:48];
      eof_r <= in_user;
    end
    if (cmd.dec) inst_r <= mrd_r;
  end

  // Result formation.
  logic [1:0]      r_st;
  logic [31:0]     r_rv;
  logic            r_ov, r_gt;
  logic [7:0]      r_oc;
  logic [PC_W-1:0] r_pc;
  always_comb begin
    r_st = ST_ACCEPT; r_rv = '0; r_ov = 1'b0; r_oc = '0; r_gt = 1'b0; r_pc = pc_r;
    if (cmd.commit) begin
      if (sts.fetch_bad || !inst_valid_r || fault) r_st = ST_FAULT;
      else if (halt) r_st = ST_HALT;
      else begin
        r_st = ST_EXEC; r_ov = pv; r_oc = pv ? rra_r[7:0] : 8'd0; r_gt = gt;
        r_pc = nxt[PC_W-1:0];
      end
    end else begin
      case (req_r)
        REQ_WRITE: r_st = idx_ok_mem ? ST_ACCEPT : ST_FAULT;
        REQ_READ: begin
          r_st = idx_ok_mem ? ST_ACCEPT : ST_FAULT;
          r_rv = idx_ok_mem ? mrd_r : 32'd0;
        end
        REQ_RREG: begin
          r_st = idx_ok_reg ? ST_ACCEPT : ST_FAULT;
          r_rv = idx_ok_reg ? rra_r : 32'd0;
        end
        REQ_SETPC: r_pc = val_r[PC_W-1:0];
        REQ_STEP:  r_st = run_r;
        default:   r_st = ST_FAULT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit || cmd.host_res) begin
      res_r <= {5'd0, r_pc, r_gt, r_oc, r_ov, r_rv, r_st};
    end
  end

endmodule

`default_nettype wire

// ===== design/small_risc_instruction_executor_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// small_risc_instruction_executor_top: single-step small RISC core
// Host requests (memory and register access, set pc, step) on one stream.
// ----------------------------------------------------------------------------
// Usage: each request arrives on the in_ stream and produces exactly one
// result on the out_ stream. Requests are handled one at a time; in_tready
// is low from acceptance until the result has been taken.
// For a write, set pc, rejected request or a step on a stopped core the result
// follows the host phase; a memory or register read adds the execute phase, a
// step whose fetch address is bad adds the fetch phase, and a step that executes
// passes the fetch, register, memory and execute phases. The step time is set
// by the single port of the data memory, used in turn for the instruction fetch
// and the load or store read-modify-write, and by the register file read that
// follows the fetch. in_tready returns the cycle after the result is taken.
// After reset the core runs a clearing pass over the larger of MEM_WORDS and
// 256 words, zeroing data memory and registers; no request is accepted until
// it has finished. pc is zero and the core is running.
// When the receiver stalls, the result is held stable in its register and no
// new request is taken until out_tready rises.
// ----------------------------------------------------------------------------
module small_risc_instruction_executor_top
  import srie_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
)(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // req_type[2:0], word_index[15:3], write_value[47:16], in_char[55:48]
  input  wire logic [IN_W-1:0]   in_tdata,
  // in_eof
  input  wire logic              in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // status[1:0], read_value[33:2], out_valid[34], out_char[42:35],
  // char_taken[43], pc_value[58:44], zero padding above
  output logic [OUT_W-1:0]       out_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  srie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .sts       (sts),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  srie_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_tdata),
    .in_user  (in_tuser),
    .sts      (sts),
    .res_data (out_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_small_risc_instruction_executor_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for small_risc_instruction_executor_top
// Host requests and single steps are driven on the input stream. A behavioural
// model of the core predicts every result, and each result is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_small_risc_instruction_executor_top;
  import srie_pkg::*;

  localparam int unsigned NWORDS    = MEM_WORDS_DEF;
  localparam int unsigned CYCLE_CAP = 400000;

  // Packed from the top bit down, so status lands in the lowest bits.
  typedef struct packed {
    logic [14:0] pc_value;
    logic        char_taken;
    logic [7:0]  out_char;
    logic        out_valid;
    logic [31:0] read_value;
    logic [1:0]  status;
  } core_result_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            in_tuser = 1'b0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // Shadow state of the core, updated as each request is sent.
  logic [31:0] shadow_regs [NUM_REGS];
  logic [31:0] shadow_mem [NWORDS];
  logic [14:0] shadow_pc;
  logic [1:0]  shadow_run;

  core_result_t pending_results[$];
  int unsigned  cycle_count = 0;
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  error_count = 0;

  always #2 clk = ~clk;

  small_risc_instruction_executor_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Any run that outlives the cap is treated as a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("small_risc_instruction_executor_top test failed");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic addr_faults(int unsigned size, logic [31:0] addr);
    return ((addr & (size - 1)) != 0) || ((addr >> 2) >= NWORDS);
  endfunction

  function automatic logic [31:0] load_bytes(int unsigned size, logic [31:0] addr);
    logic [31:0] w;
    w = shadow_mem[addr >> 2] >> (addr[1:0] * 8);
    if (size == 1) w = {{24{w[7]}}, w[7:0]};
    else if (size == 2) w = {{16{w[15]}}, w[15:0]};
    return w;
  endfunction

  // Executes the instruction at the shadow pc; returns the step status.
  function automatic logic [1:0] execute_instruction(logic [7:0] ch, logic eof,
                                                     inout core_result_t r);
    logic [31:0] pc, inst, imm, nxt, t, a, b, mask;
    logic [7:0]  op, f1, f2, f3;
    logic [4:0]  sh;
    int unsigned size;
    pc = {17'd0, shadow_pc};
    if (addr_faults(4, pc)) return ST_FAULT;
    inst = shadow_mem[pc >> 2];
    op = inst[7:0]; f1 = inst[15:8]; f2 = inst[23:16]; f3 = inst[31:24];
    imm = {{16{inst[31]}}, inst[31:16]};
    nxt = pc + 4;
    a = shadow_regs[f1];
    b = shadow_regs[f3];
    sh = b[4:0] & SHAMT_MASK;
    case (op)
      OP_LIT: shadow_regs[f1] = imm;
      OP_REL: shadow_regs[f1] = pc + imm;
      OP_JAL: begin
        t = pc + imm;
        if (addr_faults(4, t)) return ST_FAULT;
        shadow_regs[f1] = pc + 4;
        nxt = t;
      end
      OP_JALR: begin
        t = a + b;
        if (addr_faults(4, t)) return ST_FAULT;
        shadow_regs[f2] = pc + 4;
        nxt = t;
      end
      OP_BEQZ, OP_BNEZ: begin
        if ((op == OP_BEQZ) == (a == 0)) begin
          t = pc + imm;
          if (addr_faults(4, t)) return ST_FAULT;
          nxt = t;
        end
      end
      OP_ADD:  shadow_regs[f2] = a + b;
      OP_SUB:  shadow_regs[f2] = a - b;
      OP_XOR:  shadow_regs[f2] = a ^ b;
      OP_OR:   shadow_regs[f2] = a | b;
      OP_AND:  shadow_regs[f2] = a & b;
      OP_SLT:  shadow_regs[f2] = ($signed(a) < $signed(b)) ? '1 : '0;
      OP_SLTU: shadow_regs[f2] = (a < b) ? '1 : '0;
      OP_SHL:  shadow_regs[f2] = a << sh;
      OP_SHRL: shadow_regs[f2] = a >> sh;
      OP_SHRA: shadow_regs[f2] = $signed(a) >>> sh;
      OP_LB, OP_LW, OP_LD: begin
        size = (op == OP_LB) ? 1 : (op == OP_LW) ? 2 : 4;
        t = b + f2;
        if (addr_faults(size, t)) return ST_FAULT;
        shadow_regs[f1] = load_bytes(size, t);
      end
      OP_SB, OP_SW, OP_SD: begin
        size = (op == OP_SB) ? 1 : (op == OP_SW) ? 2 : 4;
        t = b + f2;
        if (addr_faults(size, t)) return ST_FAULT;
        if (size == 4) shadow_mem[t >> 2] = a;
        else begin
          mask = ((size == 1) ? 32'hff : 32'hffff) << (t[1:0] * 8);
          shadow_mem[t >> 2] = (shadow_mem[t >> 2] & ~mask) |
                               ((a << (t[1:0] * 8)) & mask);
        end
      end
      OP_SYS: begin
        if (f1 != 0 || imm != 0) return ST_FAULT;
        return ST_HALT;
      end
      OP_GETC: begin
        if (imm != 0) return ST_FAULT;
        shadow_regs[f1] = eof ? 32'hffff_ffff : {24'd0, ch};
        r.char_taken = 1'b1;
      end
      OP_PUTC: begin
        if (imm != 0) return ST_FAULT;
        r.out_valid = 1'b1;
        r.out_char = a[7:0];
      end
      default: return ST_FAULT;
    endcase
    shadow_pc = nxt[14:0];
    return ST_EXEC;
  endfunction

  function automatic core_result_t predict_request(logic [2:0] req, logic [12:0] idx,
                                                   logic [31:0] val, logic [7:0] ch,
                                                   logic eof);
    core_result_t r;
    r = '0;
    r.status = ST_ACCEPT;
    case (req)
      REQ_WRITE: if (idx < NWORDS) shadow_mem[idx] = val; else r.status = ST_FAULT;
      REQ_READ:  if (idx < NWORDS) r.read_value = shadow_mem[idx];
                 else r.status = ST_FAULT;
      REQ_RREG:  if (idx < NUM_REGS) r.read_value = shadow_regs[idx];
                 else r.status = ST_FAULT;
      REQ_SETPC: begin
        shadow_pc = val[14:0];
        shadow_run = ST_ACCEPT;
      end
      REQ_STEP: begin
        if (shadow_run != ST_ACCEPT) r.status = shadow_run;
        else begin
          r.status = execute_instruction(ch, eof, r);
          if (r.status != ST_EXEC) shadow_run = r.status;
        end
      end
      default: r.status = ST_FAULT;
    endcase
    r.pc_value = shadow_pc;
    return r;
  endfunction

  // Sends one request, predicting its result at acceptance. in_tvalid is left
  // high after acceptance and is dropped by the next idle cycle or the drain;
  // the core never accepts in the cycle after a request.
  task automatic send_request(logic [2:0] req, logic [12:0] idx, logic [31:0] val,
                              logic [7:0] ch = 8'd0, logic eof = 1'b0);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ch, val, idx, req};
    in_tuser  <= eof;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_request(req, idx, val, ch, eof));
  endtask

  function automatic logic [31:0] encode(logic [7:0] op, logic [7:0] f1,
                                         logic [7:0] f2, logic [7:0] f3);
    return {f3, f2, f1, op};
  endfunction

  function automatic logic [31:0] encode_imm(logic [7:0] op, logic [7:0] f1,
                                             logic [15:0] imm);
    return {imm, f1, op};
  endfunction

  // Places an instruction at pc and steps it.
  task automatic run_instruction(logic [31:0] inst, logic [7:0] ch = 8'd0,
                                 logic eof = 1'b0);
    if (shadow_run != ST_ACCEPT || shadow_pc[1:0] != 0 || (shadow_pc >> 2) >= NWORDS)
      send_request(REQ_SETPC, 13'd0, {17'd0, 15'($urandom_range(NWORDS - 1) << 2)});
    send_request(REQ_WRITE, 13'(shadow_pc >> 2), inst);
    send_request(REQ_STEP, 13'd0, 32'd0, ch, eof);
  endtask

  // Result checker: every accepted response is compared with the oldest prediction.
  always @(posedge clk) begin
    core_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[58:0];
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.read_value != want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, got.read_value);
          error_count++;
        end
        if (got.out_valid != want.out_valid) begin
          $error("out_valid: expected %0d, got %0d", want.out_valid, got.out_valid);
          error_count++;
        end
        if (got.out_char != want.out_char) begin
          $error("out_char: expected %h, got %h", want.out_char, got.out_char);
          error_count++;
        end
        if (got.char_taken != want.char_taken) begin
          $error("char_taken: expected %0d, got %0d", want.char_taken, got.char_taken);
          error_count++;
        end
        if (got.pc_value != want.pc_value) begin
          $error("pc_value: expected %h, got %h", want.pc_value, got.pc_value);
          error_count++;
        end
      end
    end
  end

  // Host requests at the index extremes, out of range and unknown types, and faulting steps.
  task automatic test_host_requests();
    send_request(REQ_WRITE, 13'd0, 32'hffff_ffff);
    send_request(REQ_WRITE, 13'(NWORDS - 1), 32'h8000_0001);
    send_request(REQ_READ, 13'd0, 32'd0);
    send_request(REQ_READ, 13'(NWORDS - 1), 32'd0);
    send_request(REQ_RREG, 13'd255, 32'd0);
    send_request(REQ_RREG, 13'd256, 32'd0);
    send_request(REQ_RREG, 13'h1fff, 32'd0);
    send_request(3'd5, 13'h1fff, 32'hffff_ffff, 8'hff, 1'b1);
    send_request(3'd7, 13'd0, 32'd0);
    send_request(REQ_SETPC, 13'd0, 32'hffff_fffc);
    send_request(REQ_STEP, 13'd0, 32'd0);
    send_request(REQ_STEP, 13'd0, 32'd0);
    send_request(REQ_SETPC, 13'd0, 32'd2);
    send_request(REQ_STEP, 13'd0, 32'd0);
  endtask

  // One of each opcode, plus bad encodings, halt and a misaligned jump.
  task automatic test_each_opcode();
    run_instruction(encode_imm(OP_LIT, 8'd1, 16'h8000));
    run_instruction(encode_imm(OP_LIT, 8'd2, 16'h7fff));
    run_instruction(encode_imm(OP_LIT, 8'd3, 16'd31));
    for (int op = OP_REL; op <= OP_SHRA; op++)
      run_instruction(encode(8'(op), 8'd1, 8'd4, 8'd3));
    run_instruction(encode(OP_SD, 8'd1, 8'd0, 8'd0));
    run_instruction(encode(OP_LB, 8'd5, 8'd3, 8'd0));
    run_instruction(encode(OP_LW, 8'd5, 8'd2, 8'd0));
    run_instruction(encode(OP_LD, 8'd5, 8'd1, 8'd0));
    run_instruction(encode(OP_SB, 8'd2, 8'd1, 8'd0));
    run_instruction(encode(OP_SW, 8'd2, 8'd1, 8'd0));
    run_instruction(encode(OP_GETC, 8'd6, 8'd0, 8'd0), 8'hab, 1'b0);
    run_instruction(encode(OP_GETC, 8'd6, 8'd0, 8'd0), 8'h00, 1'b1);
    run_instruction(encode(OP_PUTC, 8'd2, 8'd0, 8'd0));
    run_instruction(encode(OP_PUTC, 8'd2, 8'd0, 8'd1));
    run_instruction(encode(OP_SYS, 8'd1, 8'd0, 8'd0));
    run_instruction(encode(OP_SYS, 8'd0, 8'd0, 8'd0));
    send_request(REQ_STEP, 13'd0, 32'd0);
    run_instruction(encode_imm(OP_JAL, 8'd7, 16'd2));
    run_instruction(32'h0000_00ff);
  endtask

  // Mostly short programs of valid instructions with random operands.
  task automatic test_random_programs(int unsigned count);
    logic [7:0]  ops [] = '{OP_LIT, OP_REL, OP_JAL, OP_JALR, OP_BEQZ, OP_BNEZ, OP_ADD,
                            OP_SUB, OP_XOR, OP_OR, OP_AND, OP_SLT, OP_SLTU, OP_SHL,
                            OP_SHRL, OP_SHRA, OP_LB, OP_LW, OP_LD, OP_SB, OP_SW, OP_SD,
                            OP_SYS, OP_GETC, OP_PUTC};
    logic [7:0]  op, f1, f2, f3;
    logic [31:0] inst;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      op = ops[$urandom_range(ops.size() - 1)];
      f1 = 8'($urandom_range(15)); f2 = 8'($urandom_range(15));
      f3 = 8'($urandom_range(15));
      if ($urandom_range(9) == 0) begin
        f1 = 8'($urandom); f2 = 8'($urandom); f3 = 8'($urandom);
      end
      inst = encode(op, f1, f2, f3);
      if (op == OP_JAL || op == OP_BEQZ || op == OP_BNEZ)
        inst[31:16] = 16'($signed(int'($urandom_range(16)) - 8) * 4);
      if ((op == OP_SYS || op == OP_GETC || op == OP_PUTC) && $urandom_range(7) != 0)
        inst[31:16] = 16'd0;
      if (op == OP_SYS && $urandom_range(3) != 0) inst[15:8] = 8'd0;
      pick = $urandom_range(19);
      if (pick == 0) inst = $urandom;
      if (pick < 3)
        send_request(3'($urandom_range(7)), 13'($urandom), $urandom,
                     8'($urandom), 1'($urandom));
      else if (pick < 5)
        send_request(REQ_WRITE, 13'($urandom_range(63)), $urandom_range(1) ? $urandom
                     : 32'($urandom_range(255)));
      else if (pick < 6)
        send_request(REQ_RREG, 13'($urandom_range(15)), 32'd0);
      else
        run_instruction(inst, 8'($urandom), ($urandom_range(3) == 0));
      // A pointer register with a small aligned address keeps loads and stores useful.
      if ($urandom_range(7) == 0)
        run_instruction(encode_imm(OP_LIT, 8'($urandom_range(15)),
                                   16'($urandom_range(63) << 2)));
    end
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = '0;
    for (int i = 0; i < NWORDS; i++) shadow_mem[i] = '0;
    shadow_pc = '0;
    shadow_run = ST_ACCEPT;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_host_requests();
    test_each_opcode();
    // Random part run through idle, stall and mixed phases, with calm stretches at the start and end.
    idle_pct = 0;  stall_pct = 0;  test_random_programs(35);
    idle_pct = 65; stall_pct = 0;  test_random_programs(35);
    idle_pct = 0;  stall_pct = 65; test_random_programs(35);
    idle_pct = 20; stall_pct = 20; test_random_programs(35);
    idle_pct = 0;  stall_pct = 0;  test_random_programs(15);
    wait_for_drain();

    if (error_count == 0) begin
      $display("small_risc_instruction_executor_top test passed");
    end else begin
      $display("small_risc_instruction_executor_top test failed");
    end
    $finish;
  end

endmodule
